>>> src/wpd_pkg.sv
// Shared types and constants for the WAV PCM stream decoder.
// Holds the result record, result kinds and the RIFF chunk tags.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wpd_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_TRUNC  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] sample;
    logic        last_sample;
    logic [31:0] rate_hz;
    logic [1:0]  channel_count;
    logic [4:0]  sample_bits;
    logic [31:0] data_bytes;
  } wpd_result_t;

  // Up to two results per input byte, in delivery order; b is only set with a.
  typedef struct packed {
    logic        vld_a;
    logic        vld_b;
    wpd_result_t res_a;
    wpd_result_t res_b;
  } wpd_push_t;

  localparam logic [31:0] TAG_RIFF   = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE   = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT    = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA   = 32'h6174_6164;
  localparam logic [7:0]  PCM_OFFSET = 8'd128;
  localparam logic [31:0] FMT_MIN    = 32'd16;

endpackage

`default_nettype wire

>>> src/wpd_parser.sv
// RIFF/WAVE chunk parser: holds the parse state and turns one byte into up
// to two result records. Depends on wpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpd_parser
  import wpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [7:0] file_byte,
  input  wire logic       end_of_file,
  output wpd_push_t       push
);

  typedef enum logic [2:0] {
    PH_PRE  = 3'd0,
    PH_HDR  = 3'd1,
    PH_FMT  = 3'd2,
    PH_SKIP = 3'd3,
    PH_DATA = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  phase_t      phase_r,   phase_nxt;
  logic [3:0]  k_r,       k_nxt;
  logic [31:0] tag_r,     tag_nxt;
  logic [31:0] size_r,    size_nxt;
  logic [15:0] fcode_r,   fcode_nxt;
  logic [15:0] chans_r,   chans_nxt;
  logic [31:0] rate_r,    rate_nxt;
  logic [15:0] bits_r,    bits_nxt;
  logic [31:0] rem_r,     rem_nxt;
  logic [1:0]  fbi_r,     fbi_nxt;
  logic [7:0]  low_r,     low_nxt;

  logic [31:0] tag_shift;
  logic [31:0] size_lane;
  logic [31:0] fmt_rem;
  logic [31:0] rem_dec;
  logic [1:0]  frame_mask;
  logic [2:0]  frame_len;
  logic        fmt_ok;
  logic        step_vld;
  wpd_result_t step_res;
  logic        eof_vld;
  wpd_result_t eof_res;

  always_comb begin
    tag_shift = {file_byte, tag_r[31:8]};
    size_lane = (k_r == 4'd4) ? 32'd0 : size_r;
    size_lane[{k_r[1:0], 3'b000} +: 8] = file_byte;
    fmt_rem   = size_r - FMT_MIN;
    rem_dec   = rem_r - 32'd1;
    if (bits_r == 16'd16) begin
      frame_mask = (chans_r == 16'd2) ? 2'd3 : 2'd1;
    end else begin
      frame_mask = (chans_r == 16'd2) ? 2'd1 : 2'd0;
    end
    frame_len = {1'b0, frame_mask} + 3'd1;
    fmt_ok = (fcode_r == 16'd1) && ((bits_r == 16'd8) || (bits_r == 16'd16)) &&
             (chans_r >= 16'd1) && (chans_r <= 16'd2) && (rate_r != 32'd0) &&
             (size_lane != 32'd0);
  end

  always_comb begin
    phase_nxt = phase_r;
    k_nxt     = k_r;
    tag_nxt   = tag_r;
    size_nxt  = size_r;
    fcode_nxt = fcode_r;
    chans_nxt = chans_r;
    rate_nxt  = rate_r;
    bits_nxt  = bits_r;
    rem_nxt   = rem_r;
    fbi_nxt   = fbi_r;
    low_nxt   = low_r;
    step_vld  = 1'b0;
    step_res  = '0;
    eof_vld   = 1'b0;
    eof_res   = '0;

    if (step_en) begin
      case (phase_r)
        PH_PRE: begin
          tag_nxt = tag_shift;
          k_nxt   = k_r + 4'd1;
          if (k_r == 4'd3 && tag_shift != TAG_RIFF) begin
            step_vld      = 1'b1;
            step_res.kind = KIND_REJECT;
            phase_nxt     = PH_DONE;
          end else if (k_r >= 4'd11) begin
            if (tag_shift != TAG_WAVE) begin
              step_vld      = 1'b1;
              step_res.kind = KIND_REJECT;
              phase_nxt     = PH_DONE;
            end else begin
              phase_nxt = PH_HDR;
              k_nxt     = 4'd0;
            end
          end
        end
        PH_HDR: begin
          if (k_r < 4'd4) begin
            tag_nxt = tag_shift;
          end else begin
            size_nxt = size_lane;
          end
          k_nxt = k_r + 4'd1;
          if (k_r >= 4'd7) begin
            k_nxt = 4'd0;
            if (tag_r == TAG_FMT) begin
              if (size_lane < FMT_MIN) begin
                step_vld      = 1'b1;
                step_res.kind = KIND_REJECT;
                phase_nxt     = PH_DONE;
              end else begin
                phase_nxt = PH_FMT;
              end
            end else if (tag_r == TAG_DATA) begin
              step_vld = 1'b1;
              if (fmt_ok) begin
                step_res.kind          = KIND_ACCEPT;
                step_res.rate_hz       = rate_r;
                step_res.channel_count = chans_r[1:0];
                step_res.sample_bits   = bits_r[4:0];
                step_res.data_bytes    = size_lane;
                phase_nxt              = PH_DATA;
                rem_nxt                = size_lane;
                fbi_nxt                = 2'd0;
              end else begin
                step_res.kind = KIND_REJECT;
                phase_nxt     = PH_DONE;
              end
            end else begin
              tag_nxt   = {31'd0, size_lane[0]};
              phase_nxt = (size_lane == 32'd0) ? PH_HDR : PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          if (k_r < 4'd2) begin
            fcode_nxt[{k_r[0], 3'b000} +: 8] = file_byte;
          end else if (k_r < 4'd4) begin
            chans_nxt[{k_r[0], 3'b000} +: 8] = file_byte;
          end else if (k_r < 4'd8) begin
            rate_nxt[{k_r[1:0], 3'b000} +: 8] = file_byte;
          end else if (k_r >= 4'd14) begin
            bits_nxt[{k_r[0], 3'b000} +: 8] = file_byte;
          end
          k_nxt = k_r + 4'd1;
          if (k_r == 4'd15) begin
            k_nxt     = 4'd0;
            size_nxt  = fmt_rem;
            tag_nxt   = {31'd0, size_r[0]};
            phase_nxt = (fmt_rem == 32'd0) ? PH_HDR : PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (size_r != 32'd0) begin
            size_nxt = size_r - 32'd1;
            if (size_r == 32'd1 && !tag_r[0]) begin
              phase_nxt = PH_HDR;
              k_nxt     = 4'd0;
            end
          end else begin
            tag_nxt   = 32'd0;
            phase_nxt = PH_HDR;
            k_nxt     = 4'd0;
          end
        end
        PH_DATA: begin
          rem_nxt = rem_dec;
          if (bits_r == 16'd8) begin
            if (fbi_r == 2'd0) begin
              step_vld             = 1'b1;
              step_res.kind        = KIND_SAMPLE;
              step_res.sample      = {file_byte ^ PCM_OFFSET, 8'h00};
              step_res.last_sample = rem_dec < {29'd0, frame_len};
            end
          end else begin
            if (fbi_r == 2'd0) begin
              low_nxt = file_byte;
            end else if (fbi_r == 2'd1) begin
              step_vld             = 1'b1;
              step_res.kind        = KIND_SAMPLE;
              step_res.sample      = {file_byte, low_r};
              step_res.last_sample = rem_dec < {29'd0, frame_len};
            end
          end
          fbi_nxt = (fbi_r + 2'd1) & frame_mask;
          if (rem_dec == 32'd0) begin
            phase_nxt = PH_DONE;
          end
        end
        default: begin
        end
      endcase

      if (end_of_file) begin
        if (phase_nxt == PH_PRE || phase_nxt == PH_HDR || phase_nxt == PH_FMT ||
            phase_nxt == PH_SKIP) begin
          eof_vld      = 1'b1;
          eof_res.kind = KIND_REJECT;
        end else if (phase_nxt == PH_DATA && rem_nxt != 32'd0) begin
          eof_vld      = 1'b1;
          eof_res.kind = KIND_TRUNC;
        end
        phase_nxt = PH_PRE;
        k_nxt     = 4'd0;
        tag_nxt   = 32'd0;
        size_nxt  = 32'd0;
        fcode_nxt = 16'd0;
        chans_nxt = 16'd0;
        rate_nxt  = 32'd0;
        bits_nxt  = 16'd0;
        rem_nxt   = 32'd0;
        fbi_nxt   = 2'd0;
        low_nxt   = 8'd0;
      end
    end
  end

  always_comb begin
    push.vld_a = step_vld | eof_vld;
    push.vld_b = step_vld & eof_vld;
    push.res_a = step_vld ? step_res : eof_res;
    push.res_b = eof_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PRE;
      k_r     <= 4'd0;
      tag_r   <= 32'd0;
      size_r  <= 32'd0;
      fcode_r <= 16'd0;
      chans_r <= 16'd0;
      rate_r  <= 32'd0;
      bits_r  <= 16'd0;
      rem_r   <= 32'd0;
      fbi_r   <= 2'd0;
      low_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      k_r     <= k_nxt;
      tag_r   <= tag_nxt;
      size_r  <= size_nxt;
      fcode_r <= fcode_nxt;
      chans_r <= chans_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
      rem_r   <= rem_nxt;
      fbi_r   <= fbi_nxt;
      low_r   <= low_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/wav_pcm_stream_decoder.sv
// WAV PCM stream decoder top level: input register, parser and result queue.
// Depends on wpd_pkg and wpd_parser.
//
// Usage:
//   Slave channel (in_*): one byte of a WAV file per beat in in_tdata,
//   in_tlast on the final byte of the file; the parser returns to its
//   reset state after that byte.
//   Master channel (out_*): result beats. out_tuser carries the kind
//   (sample, header accepted, header rejected, data truncated), out_tlast
//   marks the final sample of the data chunk, out_tdata the sample and the
//   format fields.
//   Throughput: one byte per cycle while the result queue has two free slots.
//   A byte is registered at the input, parsed from that register and its
//   results (none, one or two) written to a four-beat result queue; the
//   master side offers results from the queue head once they are written.
//   A byte that yields two results (accept or sample followed by an end of
//   file status) is still parsed in one step; the queue absorbs the extra beat.
//   When the receiver stalls the queue fills; the input register holds its
//   byte until two queue slots are free, and in_tready drops while it waits.
//   Reset (rst_n low, synchronous) empties the queue and the input register
//   and returns the parser to expecting the RIFF tag.
`timescale 1ns / 1ps
`default_nettype none

module wav_pcm_stream_decoder
  import wpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] file_byte
  input  wire logic        in_tlast,   // end_of_file
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // [15:0] sample, [47:16] rate in Hz,
                                       // [49:48] channel_count, [54:50] sample_bits,
                                       // [86:55] data_bytes, [87] zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast   // last_sample
);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  logic            in_vld_r;
  logic [7:0]      in_byte_r;
  logic            in_eof_r;
  logic            step_en;
  wpd_push_t       push;

  wpd_result_t     queue_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]  cnt_r,    cnt_nxt;
  logic [QCW-1:0]  n_push;
  logic            pop;
  wpd_result_t     head;

  assign step_en   = in_vld_r && (cnt_r <= QCW'(QDEPTH - 2));
  assign in_tready = !in_vld_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (step_en) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eof_r  <= in_tlast;
    end
  end

  wpd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .file_byte   (in_byte_r),
    .end_of_file (in_eof_r),
    .push        (push)
  );

  assign head       = queue_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last_sample;
  assign out_tdata  = {1'b0, head.data_bytes, head.sample_bits, head.channel_count,
                       head.rate_hz, head.sample};

  always_comb begin
    n_push     = QCW'(push.vld_a) + QCW'(push.vld_b);
    cnt_nxt    = cnt_r + n_push - QCW'(pop);
    wr_ptr_nxt = wr_ptr_r + QAW'(n_push);
    rd_ptr_nxt = rd_ptr_r + QAW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.vld_a) begin
      queue_r[wr_ptr_r] <= push.res_a;
    end
    if (push.vld_b) begin
      queue_r[wr_ptr_r + QAW'(1)] <= push.res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/wpd_checker.sv
// Port-level checks for wav_pcm_stream_decoder, bound to the top level.
// Depends on wpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpd_checker
  import wpd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  in_tdata,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Reset empties the result queue.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat offered straight after reset");

  // Status beats carry no sample and no last mark.
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_SAMPLE |-> !out_tlast && out_tdata[15:0] == 16'd0)
    else $error("status beat carries sample fields");

  // An accepted header always reports a format that passed the check.
  a_accept_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ACCEPT |->
      (out_tdata[49:48] == 2'd1 || out_tdata[49:48] == 2'd2) &&
      (out_tdata[54:50] == 5'd8 || out_tdata[54:50] == 5'd16) &&
      out_tdata[47:16] != 32'd0 && out_tdata[86:55] != 32'd0)
    else $error("accepted header with invalid format");

endmodule

bind wav_pcm_stream_decoder wpd_checker u_wpd_checker (.*);

`default_nettype wire

>>> bench/wav_pcm_stream_decoder_test.sv
// Self-checking testbench for the WAV PCM stream decoder: whole WAV files go in byte
// by byte, and every result beat is checked against a behavioural model of the parser.
// Depends on wpd_pkg and wav_pcm_stream_decoder.
`timescale 1ns / 1ps

module wav_pcm_stream_decoder_test;
  import wpd_pkg::*;

  localparam int STALL_PCT      = 18;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 60;
  localparam int DRAIN_CYCLES   = 10;

  localparam logic [31:0] TAG_RIFX = 32'h5846_4952;
  localparam logic [31:0] TAG_WAVF = 32'h4656_4157;
  localparam logic [31:0] TAG_LIST = 32'h5453_494C;
  localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;

  typedef enum logic [2:0] {
    PH_PREAMBLE, PH_HEADER, PH_FORMAT, PH_SKIP, PH_DATA, PH_DONE
  } phase_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  phase_t      phase;
  logic [31:0] field_count;
  logic [31:0] tag_acc;
  logic [31:0] size_acc;
  logic        pad_pending;
  logic [15:0] fmt_code;
  logic [15:0] fmt_channels;
  logic [31:0] fmt_rate;
  logic [15:0] fmt_bits;
  logic [31:0] data_left;
  logic [1:0]  frame_pos;
  logic [7:0]  held_low;

  wpd_result_t expected_results[$];
  logic [7:0]  file_q[$];
  int          live_bytes  = 0;
  int          error_count = 0;
  int          idle_cycles = 0;
  bit          stalls_on   = 1'b1;

  wav_pcm_stream_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Parser model

  function automatic void clear_parser();
    phase        = PH_PREAMBLE;
    field_count  = '0;
    tag_acc      = '0;
    size_acc     = '0;
    pad_pending  = 1'b0;
    fmt_code     = '0;
    fmt_channels = '0;
    fmt_rate     = '0;
    fmt_bits     = '0;
    data_left    = '0;
    frame_pos    = '0;
    held_low     = '0;
  endfunction

  function automatic void expect_result(kind_t kind, logic [15:0] smp, logic last,
                                        logic [31:0] rate, logic [15:0] ch,
                                        logic [15:0] bits, logic [31:0] size);
    wpd_result_t r;
    r.kind          = kind;
    r.sample        = smp;
    r.last_sample   = last;
    r.rate_hz       = rate;
    r.channel_count = ch[1:0];
    r.sample_bits   = bits[4:0];
    r.data_bytes    = size;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void expect_status(kind_t kind);
    expect_result(kind, '0, 1'b0, '0, '0, '0, '0);
  endfunction

  function automatic void start_skip(logic [31:0] remaining, logic pad);
    size_acc    = remaining;
    pad_pending = pad;
    field_count = '0;
    phase       = (remaining == 0 && !pad) ? PH_HEADER : PH_SKIP;
  endfunction

  function automatic void decode_file_byte(logic [7:0] b, logic eof);
    logic [31:0] k;
    logic [31:0] frame_len;
    logic [1:0]  pos;
    int          lane;
    k    = field_count;
    lane = int'(k[1:0]);
    if (phase != PH_DONE) live_bytes++;
    case (phase)
      PH_PREAMBLE: begin
        tag_acc     = {b, tag_acc[31:8]};
        field_count = k + 1;
        if (k == 3 && tag_acc != TAG_RIFF) begin
          expect_status(KIND_REJECT);
          phase = PH_DONE;
        end else if (k >= 11) begin
          if (tag_acc != TAG_WAVE) begin
            expect_status(KIND_REJECT);
            phase = PH_DONE;
          end else begin
            phase       = PH_HEADER;
            field_count = '0;
          end
        end
      end
      PH_HEADER: begin
        if (k < 4) begin
          tag_acc = {b, tag_acc[31:8]};
        end else begin
          if (k == 4) size_acc = '0;
          size_acc[lane*8 +: 8] = b;
        end
        field_count = k + 1;
        if (k >= 7) begin
          field_count = '0;
          if (tag_acc == TAG_FMT) begin
            if (size_acc < FMT_MIN) begin
              expect_status(KIND_REJECT);
              phase = PH_DONE;
            end else begin
              phase = PH_FORMAT;
            end
          end else if (tag_acc == TAG_DATA) begin
            if (fmt_code == 16'd1 && (fmt_bits == 16'd8 || fmt_bits == 16'd16) &&
                fmt_channels >= 16'd1 && fmt_channels <= 16'd2 &&
                fmt_rate != 0 && size_acc != 0) begin
              expect_result(KIND_ACCEPT, '0, 1'b0, fmt_rate, fmt_channels, fmt_bits,
                            size_acc);
              phase     = PH_DATA;
              data_left = size_acc;
              frame_pos = '0;
            end else begin
              expect_status(KIND_REJECT);
              phase = PH_DONE;
            end
          end else begin
            start_skip(size_acc, size_acc[0]);
          end
        end
      end
      PH_FORMAT: begin
        if (k < 2) fmt_code[(lane % 2)*8 +: 8] = b;
        else if (k < 4) fmt_channels[(lane % 2)*8 +: 8] = b;
        else if (k < 8) fmt_rate[lane*8 +: 8] = b;
        else if (k >= 14 && k < 16) fmt_bits[(lane % 2)*8 +: 8] = b;
        field_count = k + 1;
        if (k >= 15) start_skip(size_acc - FMT_MIN, size_acc[0]);
      end
      PH_SKIP: begin
        if (size_acc > 0) size_acc--;
        else pad_pending = 1'b0;
        if (size_acc == 0 && !pad_pending) begin
          phase       = PH_HEADER;
          field_count = '0;
        end
      end
      PH_DATA: begin
        frame_len = 32'(fmt_bits >> 3) * 32'(fmt_channels);
        pos       = frame_pos;
        data_left--;
        if (fmt_bits == 16'd8) begin
          if (pos == 0)
            expect_result(KIND_SAMPLE, {b ^ PCM_OFFSET, 8'h00}, data_left < frame_len,
                          '0, '0, '0, '0);
        end else begin
          if (pos == 0) held_low = b;
          else if (pos == 1)
            expect_result(KIND_SAMPLE, {b, held_low}, data_left < frame_len,
                          '0, '0, '0, '0);
        end
        frame_pos = (frame_len == 0) ? 2'd0 : 2'((32'(pos) + 32'd1) % frame_len);
        if (data_left == 0) phase = PH_DONE;
      end
      default: ;
    endcase
    if (eof) begin
      if (phase <= PH_SKIP) expect_status(KIND_REJECT);
      else if (phase == PH_DATA && data_left != 0) expect_status(KIND_TRUNC);
      clear_parser();
    end
  endfunction

  // File assembly

  function automatic void put_u8(logic [7:0] v);
    file_q.insert(file_q.size(), v);
  endfunction

  function automatic void put_u16(logic [15:0] v);
    put_u8(v[7:0]);
    put_u8(v[15:8]);
  endfunction

  function automatic void put_u32(logic [31:0] v);
    put_u16(v[15:0]);
    put_u16(v[31:16]);
  endfunction

  function automatic void put_preamble();
    put_u32(TAG_RIFF);
    put_u32($urandom);
    put_u32(TAG_WAVE);
  endfunction

  function automatic void put_fmt(logic [31:0] size, logic [15:0] code, logic [15:0] ch,
                                  logic [31:0] rate, logic [15:0] bits);
    put_u32(TAG_FMT);
    put_u32(size);
    put_u16(code);
    put_u16(ch);
    put_u32(rate);
    put_u32(rate * ch * (bits >> 3));
    put_u16(ch * (bits >> 3));
    put_u16(bits);
    for (int unsigned i = 16; i < size; i++) put_u8(8'($urandom));
    if (size[0]) put_u8(8'($urandom));
  endfunction

  function automatic void put_chunk(logic [31:0] tag, int unsigned len);
    put_u32(tag);
    put_u32(len);
    repeat (len) put_u8(8'($urandom));
    if (len % 2) put_u8(8'($urandom));
  endfunction

  function automatic void put_data(logic [31:0] size, int unsigned len);
    put_u32(TAG_DATA);
    put_u32(size);
    repeat (len) put_u8(8'($urandom));
  endfunction

  function automatic void build_random_file();
    int unsigned pick;
    int unsigned len;
    int unsigned keep;
    int unsigned at;
    logic [31:0] size;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 12)) put_u8(8'($urandom));
      return;
    end
    put_preamble();
    if (pick < 14) begin
      at         = $urandom_range(11);
      file_q[at] = file_q[at] ^ 8'(1 << $urandom_range(7));
    end
    if ($urandom_range(3) == 0) put_chunk($urandom, $urandom_range(5));
    if ($urandom_range(7) == 0)
      put_fmt(32'(16 + $urandom_range(2)), 16'($urandom), 16'($urandom), $urandom,
              16'($urandom));
    put_fmt(($urandom_range(24) == 0) ? 32'($urandom_range(15)) : 32'(16 + $urandom_range(3)),
            ($urandom_range(11) == 0) ? 16'($urandom) : 16'd1,
            ($urandom_range(11) == 0) ? 16'($urandom_range(3)) : 16'($urandom_range(1, 2)),
            ($urandom_range(24) == 0) ? 32'd0 : 32'($urandom),
            ($urandom_range(11) == 0) ? 16'($urandom_range(40)) :
                                        ($urandom_range(1) ? 16'd16 : 16'd8));
    if ($urandom_range(4) == 0) put_chunk($urandom, $urandom_range(5));
    len = $urandom_range(1, 24);
    case ($urandom_range(19))
      0:       size = '0;
      1:       size = $urandom;
      2:       size = 32'(len + $urandom_range(1, 4));
      default: size = len;
    endcase
    put_data(size, len + (($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0));
    if (pick < 22) begin
      keep = $urandom_range(1, file_q.size());
      while (file_q.size() > keep) void'(file_q.pop_back());
    end
  endfunction

  // Stimulus

  task automatic send_byte(logic [7:0] b, logic eof);
    while (stalls_on && $urandom_range(99) < STALL_PCT) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
  endtask

  task automatic test_bad_riff();
    put_u32(TAG_RIFX);
    repeat (3) put_u8(8'($urandom));
    send_file();
  endtask

  task automatic test_bad_wave();
    put_u32(TAG_RIFF);
    put_u32(32'hFFFF_FFFF);
    put_u32(TAG_WAVF);
    send_file();
  endtask

  task automatic test_early_end();
    put_u32(TAG_RIFF);
    put_u16(16'h0000);
    send_file();
  endtask

  task automatic test_short_fmt();
    put_preamble();
    put_u32(TAG_FMT);
    put_u32(32'd15);
    put_u16(16'd1);
    send_file();
  endtask

  task automatic test_missing_fmt();
    put_preamble();
    put_data(32'd4, 4);
    send_file();
  endtask

  task automatic test_end_in_skip();
    put_preamble();
    put_u32(TAG_JUNK);
    put_u32(32'd5);
    put_u16(16'hA55A);
    send_file();
  endtask

  task automatic test_format_rejects();
    put_preamble();
    put_fmt(32'd16, 16'd1, 16'd2, 32'd0, 16'd16);
    put_data(32'd4, 4);
    send_file();
    put_preamble();
    put_fmt(32'd16, 16'd1, 16'd2, 32'd48000, 16'd8);
    put_data(32'd0, 2);
    send_file();
  endtask

  task automatic test_mono8_extremes();
    put_preamble();
    put_fmt(32'd16, 16'd1, 16'd1, 32'hFFFF_FFFF, 16'd8);
    put_data(32'd5, 0);
    put_u8(8'h00);
    put_u8(8'hFF);
    put_u8(8'h80);
    put_u8(8'h7F);
    put_u8(8'h01);
    put_u16(16'hFFFF);
    send_file();
  endtask

  task automatic test_stereo16_chunks();
    put_preamble();
    put_chunk(TAG_LIST, 3);
    put_fmt(32'd16, 16'd3, 16'd1, 32'd8000, 16'd8);
    put_fmt(32'd17, 16'd1, 16'd2, 32'd44100, 16'd16);
    put_data(32'd9, 0);
    put_u16(16'h8000);
    put_u16(16'h1234);
    put_u16(16'h7FFF);
    put_u16(16'hFFFF);
    put_u8(8'h01);
    send_file();
  endtask

  task automatic test_short_data();
    put_preamble();
    put_fmt(32'd16, 16'd1, 16'd1, 32'd22050, 16'd16);
    put_data(32'hFFFF_FFFF, 3);
    send_file();
    put_preamble();
    put_fmt(32'd16, 16'd1, 16'd1, 32'd11025, 16'd8);
    put_data(32'd10, 2);
    send_file();
  endtask

  task automatic test_random_files();
    int goal;
    goal      = live_bytes + RANDOM_BYTES;
    stalls_on = 1'b0;
    while (live_bytes < goal) begin
      if (live_bytes > goal - RANDOM_BYTES * 3 / 4) stalls_on = 1'b1;
      build_random_file();
      send_file();
    end
  endtask

  // Checking

  task automatic report(string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  always @(negedge clk) begin
    out_tready <= !stalls_on || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    wpd_result_t want;
    if (rst_n && in_tvalid && in_tready) decode_file_byte(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report($sformatf("result beat of kind %0d with none expected", out_tuser));
      end else begin
        want = expected_results.pop_front();
        check_field("kind", out_tuser, want.kind);
        check_field("sample", out_tdata[15:0], want.sample);
        check_field("last_sample", out_tlast, want.last_sample);
        check_field("rate_hz", out_tdata[47:16], want.rate_hz);
        check_field("channel_count", out_tdata[49:48], want.channel_count);
        check_field("sample_bits", out_tdata[54:50], want.sample_bits);
        check_field("data_bytes", out_tdata[86:55], want.data_bytes);
        check_field("tdata pad bit", out_tdata[87], 1'b0);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("wav_pcm_stream_decoder_test failed");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_bad_riff();
    test_bad_wave();
    test_early_end();
    test_short_fmt();
    test_missing_fmt();
    test_end_in_skip();
    test_format_rejects();
    test_mono8_extremes();
    test_stereo16_chunks();
    test_short_data();
    test_random_files();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("wav_pcm_stream_decoder_test passed");
    end else begin
      $display("wav_pcm_stream_decoder_test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/wpd_pkg.sv
src/wpd_parser.sv
src/wav_pcm_stream_decoder.sv
src/wpd_checker.sv
bench/wav_pcm_stream_decoder_test.sv
